>>> hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the lamp phase sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising edge of clk, held off while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on the rising edge of clk, held off while rst_n is low.
`define ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication checked on the rising edge of clk, held off during reset.
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> hdl/tcps_pkg.sv
// Package with the types, codes and constants of the lamp phase sequencer.
`timescale 1ns / 1ps

package tcps_pkg;

    // Width of one color channel that is actually used.
    localparam int COLOR_BITS = 8;
    localparam logic [7:0] COLOR_MASK = 8'((32'd1 << COLOR_BITS) - 32'd1);

    // Configuration register reset values.
    localparam logic [15:0] RELAY_DELAY_RESET = 16'd3000;
    localparam logic [15:0] COLOR_DELAY_RESET = 16'd2000;
    localparam logic [7:0]  COLOR_MAX_RESET   = 8'd255;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RELAY_DELAY = 2'd0;
    localparam logic [1:0] CFG_COLOR_DELAY = 2'd1;
    localparam logic [1:0] CFG_COLOR_MAX   = 2'd2;

    // Input item modes.
    localparam logic MODE_STEP  = 1'b0;
    localparam logic MODE_START = 1'b1;

    // Relay commands.
    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_ON   = 2'd1;
    localparam logic [1:0] CMD_OFF  = 2'd2;

    // Sequencer phases.
    localparam logic [2:0] PH_RELAY     = 3'd0;
    localparam logic [2:0] PH_RAMP_UP   = 3'd1;
    localparam logic [2:0] PH_DARK_A    = 3'd2;
    localparam logic [2:0] PH_GREEN     = 3'd3;
    localparam logic [2:0] PH_BLUE      = 3'd4;
    localparam logic [2:0] PH_RED       = 3'd5;
    localparam logic [2:0] PH_DARK_B    = 3'd6;
    localparam logic [2:0] PH_RAMP_DOWN = 3'd7;

    typedef struct packed {
        logic        mode;
        logic [31:0] now;
        logic [3:0]  relay_select;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [1:0] relay_command;
        logic [3:0] relay_index;
    } out_item_t;

    typedef struct packed {
        logic [15:0] relay_delay;
        logic [15:0] color_delay;
        logic [7:0]  color_max;
    } cfg_t;

endpackage

>>> hdl/tcps_cfg.sv
// Configuration register file of the lamp phase sequencer.
`timescale 1ns / 1ps

module tcps_cfg
    import tcps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [15:0] wr_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.relay_delay <= RELAY_DELAY_RESET;
            cfg_reg.color_delay <= COLOR_DELAY_RESET;
            cfg_reg.color_max   <= COLOR_MAX_RESET;
        end
        else if (wr_en)
        begin
            // Writes to an index beyond the register list are dropped.
            unique case (wr_index)
                CFG_RELAY_DELAY: cfg_reg.relay_delay <= wr_data;
                CFG_COLOR_DELAY: cfg_reg.color_delay <= wr_data;
                CFG_COLOR_MAX:   cfg_reg.color_max   <= wr_data[7:0];
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hdl/tcps_step.sv
// Phase state and combinational next-state logic of the lamp phase sequencer.
`timescale 1ns / 1ps

module tcps_step
    import tcps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t res
);

    logic [2:0]  phase_reg,    phase_next;
    logic [31:0] deadline_reg, deadline_next;
    logic [7:0]  blue_reg,     blue_next;
    logic [3:0]  relay_reg,    relay_next;

    logic        due;
    logic [7:0]  top;
    logic [31:0] relay_dl;
    logic [31:0] color_dl;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [1:0]  cmd;

    assign due      = item.now >= deadline_reg;
    assign top      = cfg.color_max & COLOR_MASK;
    assign relay_dl = item.now + {16'd0, cfg.relay_delay};
    assign color_dl = item.now + {16'd0, cfg.color_delay};

    always_comb
    begin
        phase_next    = phase_reg;
        deadline_next = deadline_reg;
        blue_next     = blue_reg;
        relay_next    = relay_reg;
        red           = 8'd0;
        green         = 8'd0;
        cmd           = CMD_NONE;
        if (item.mode == MODE_START)
        begin
            phase_next    = PH_RELAY;
            deadline_next = relay_dl;
            blue_next     = 8'd0;
            relay_next    = item.relay_select;
            cmd           = CMD_ON;
        end
        else
        begin
            unique case (phase_reg)
                PH_RELAY:
                begin
                    if (due)
                    begin
                        phase_next = PH_RAMP_UP;
                        cmd        = CMD_OFF;
                    end
                end
                PH_RAMP_UP:
                begin
                    if (blue_reg < top)
                    begin
                        blue_next = (blue_reg + 8'd1) & COLOR_MASK;
                    end
                    else
                    begin
                        phase_next    = PH_DARK_A;
                        deadline_next = color_dl;
                    end
                end
                PH_DARK_A, PH_BLUE:
                begin
                    if (due)
                    begin
                        phase_next    = phase_reg + 3'd1;
                        deadline_next = color_dl;
                        blue_next     = 8'd0;
                    end
                end
                PH_GREEN, PH_RED:
                begin
                    if (due)
                    begin
                        phase_next    = phase_reg + 3'd1;
                        deadline_next = color_dl;
                        blue_next     = top;
                    end
                    // The channel stays lit on the step that ends the phase too.
                    if (phase_reg == PH_GREEN)
                    begin
                        green = top;
                    end
                    else
                    begin
                        red = top;
                    end
                end
                PH_DARK_B:
                begin
                    if (due)
                    begin
                        phase_next    = PH_RAMP_DOWN;
                        deadline_next = color_dl;
                    end
                end
                default:
                begin
                    // Ramp down; a level above the maximum still counts to zero.
                    if (blue_reg != 8'd0)
                    begin
                        blue_next = blue_reg - 8'd1;
                    end
                    else
                    begin
                        phase_next    = PH_RELAY;
                        deadline_next = relay_dl;
                        cmd           = CMD_ON;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_RELAY;
            deadline_reg <= 32'd0;
            blue_reg     <= 8'd0;
            relay_reg    <= 4'd0;
        end
        else if (en)
        begin
            phase_reg    <= phase_next;
            deadline_reg <= deadline_next;
            blue_reg     <= blue_next;
            relay_reg    <= relay_next;
        end
    end

    assign res.red           = red;
    assign res.green         = green;
    assign res.blue          = blue_next;
    assign res.relay_command = cmd;
    assign res.relay_index   = relay_next;

endmodule

>>> hdl/timed_color_phase_sequencer.sv
// Top level of the timed lamp phase sequencer: handshake stages, config and step logic.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The sequencer takes one item per clock cycle while the result channel is not
// stalled, and returns exactly one result for each item: the item is captured
// in an input register, the phase state is updated from it as it leaves that
// register, and the result is held in an output register until the downstream
// side takes it. The rate of one item per cycle is set by the phase state
// update, a single 32-bit deadline compare and add. A start item (mode 1)
// latches the relay number, returns to the relay phase and answers with a
// relay-activate command; a step item (mode 0) carries the current time and
// moves the eight-phase color loop along. Deadlines wrap modulo 2^32 and are
// compared without wrap handling. The configuration port is always ready;
// registers are to be written only while the block is idle.
module timed_color_phase_sequencer
    import tcps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Item channel.
    input  logic        item_valid,
    output logic        item_stall,
    input  in_item_t    item,
    // Result channel.
    output logic        result_valid,
    input  logic        result_stall,
    output out_item_t   result,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // Input register stage.
    logic      s1_valid_reg, s1_valid_next;
    in_item_t  s1_item_reg;
    // Output register stage.
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg;

    logic      s1_move;
    logic      item_take;
    cfg_t      cfg;
    out_item_t step_res;

    // The held item moves on when the output register is empty or being emptied.
    assign s1_move    = s1_valid_reg && (!out_valid_reg || !result_stall);
    // A new item enters when the input register is empty or moving on this cycle.
    assign item_stall = s1_valid_reg && !s1_move;
    assign item_take  = item_valid && !item_stall;
    assign cfg_ready  = 1'b1;

    tcps_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // The phase state advances exactly once per item, as it leaves the input stage.
    tcps_step u_step
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (s1_move),
        .item  (s1_item_reg),
        .cfg   (cfg),
        .res   (step_res)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (item_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset; their valid flags qualify them.
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            s1_item_reg <= item;
        end
        if (s1_move)
        begin
            out_item_reg <= step_res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    // A held item that cannot move on is still held in the next cycle.
    `ASSERT_NEXT(a_s1_hold, s1_valid_reg && !s1_move, s1_valid_reg, "input stage item lost")
    // An item is never taken into a full input stage that is not draining.
    `ASSERT_IMPL(a_no_overrun, item_take, !s1_valid_reg || s1_move, "input stage overrun")
    // Every item leaving the input stage shows up as a result.
    `ASSERT_NEXT(a_move_result, s1_move, result_valid, "result missing after stage move")
    // A taken result with nothing behind it leaves the output empty.
    `ASSERT_NEXT(a_no_repeat, result_valid && !result_stall && !s1_move, !result_valid,
        "result repeated")

endmodule
